>>> rtl/pzos_pkg.sv
`timescale 1ns / 1ps

package pzos_pkg;

    // Fixed field widths.
    localparam int PLANE_W = 3;
    localparam int ZOOM_W  = 6;
    localparam int LEVEL_W = 7;
    localparam int COUNT_W = 9;
    localparam int LAG_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int DEFAULT_MAX_PLANES = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PLANES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_ZOOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_ZOOM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_FLAT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [PLANE_W-1:0] NUM_PLANES_RST = 3'd3;
    localparam logic [ZOOM_W-1:0]  BEGIN_ZOOM_RST = 6'd0;
    localparam logic [ZOOM_W-1:0]  END_ZOOM_RST   = 6'd0;

    // Outcome of the plane selection.
    typedef struct packed {
        logic               found;
        logic [PLANE_W-1:0] plane;
    } sel_t;

    // Allowed lag of a plane behind the priority plane.
    function automatic logic [LAG_W-1:0] lag_of(input logic [PLANE_W-1:0] p,
                                                input logic flat);
        logic [LAG_W-1:0] lag;
        lag = '0;
        case (p)
            3'd1:    lag = flat ? 3'd0 : 3'd2;
            3'd2:    lag = flat ? 3'd1 : 3'd4;
            default: lag = '0;
        endcase
        return lag;
    endfunction

endpackage

>>> rtl/pzos_select.sv
`timescale 1ns / 1ps

// Picks the plane for the next entry: the last plane that lags the priority
// plane too far, else the priority plane, then skips finished planes with wrap.
module pzos_select #(
    parameter int MAX_PLANES = pzos_pkg::DEFAULT_MAX_PLANES
) (
    input  logic [pzos_pkg::LEVEL_W-1:0] levels [MAX_PLANES],
    input  logic [pzos_pkg::PLANE_W-1:0] np,
    input  logic [pzos_pkg::ZOOM_W-1:0]  end_zoom,
    input  logic                         luma_flat,
    output pzos_pkg::sel_t               sel
);

    localparam int PIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    logic [pzos_pkg::PLANE_W-1:0] hp;
    logic [pzos_pkg::PLANE_W-1:0] pick;
    logic [pzos_pkg::LEVEL_W:0]   hp_limit;
    logic [pzos_pkg::PLANE_W:0]   idx;
    logic [pzos_pkg::PLANE_W-1:0] cand;

    always_comb
    begin
        hp = '0;
        if (np >= 3'd4)
        begin
            hp = 3'd3;
        end
        if (np >= 3'd5)
        begin
            hp = 3'd4;
        end

        pick     = hp;
        hp_limit = '0;
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            hp_limit = {1'b0, levels[hp[PIDX_W-1:0]]}
                     + (pzos_pkg::LEVEL_W + 1)'(pzos_pkg::lag_of(
                           pzos_pkg::PLANE_W'(p), luma_flat));
            if ((pzos_pkg::PLANE_W'(p) < np) &&
                ({1'b0, levels[p]} > hp_limit))
            begin
                pick = pzos_pkg::PLANE_W'(p);
            end
        end

        // Walk from the highest offset down so the nearest unfinished plane wins.
        sel  = '0;
        idx  = '0;
        cand = '0;
        for (int k = MAX_PLANES - 1; k >= 0; k--)
        begin
            idx = {1'b0, pick} + (pzos_pkg::PLANE_W + 1)'(k);
            if (idx >= {1'b0, np})
            begin
                idx = idx - {1'b0, np};
            end
            cand = idx[pzos_pkg::PLANE_W-1:0];
            if ((pzos_pkg::PLANE_W'(k) < np) &&
                (levels[cand[PIDX_W-1:0]] > {1'b0, end_zoom}))
            begin
                sel.found = 1'b1;
                sel.plane = cand;
            end
        end
    end

endmodule

>>> rtl/plane_zoom_order_scheduler_core.sv
`timescale 1ns / 1ps

// Interlaced coding order scheduler. Every transfer on the input channel
// (in_valid/in_stall, payload restart) yields exactly one transfer on the
// output channel (out_valid/out_stall, payload plane, zoom, last, past_end),
// in order. A restart item reloads every plane level with begin_zoom plus
// one and returns the first entry of the sequence; other items return the
// next entry, or past_end when the sequence is exhausted.
// An item taken is registered in the input register; its entry is computed
// from the level counters and lands in the result register once it frees
// up. Throughput is one item per cycle while the receiver does not stall,
// set by the single select-and-decrement path over the MAX_PLANES level counters.
// When the receiver stalls, the result register holds its transfer; the
// input register still fills, and in_stall rises only while both are full.
// The configuration registers (num_planes, begin_zoom, end_zoom, luma_flat)
// are written through cfg_wr_en/cfg_index/cfg_data and should only change
// while the block is idle. Reset clears both channels, loads the register
// defaults and sets every plane level to one with no entries given.
module plane_zoom_order_scheduler_core #(
    parameter int MAX_PLANES = pzos_pkg::DEFAULT_MAX_PLANES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pzos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pzos_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pzos_pkg::PLANE_W-1:0]    plane,
    output logic [pzos_pkg::ZOOM_W-1:0]     zoom,
    output logic                            last,
    output logic                            past_end
);

    localparam logic [pzos_pkg::PLANE_W-1:0] MAX_NP = pzos_pkg::PLANE_W'(MAX_PLANES);

    // Configuration registers.
    logic [pzos_pkg::PLANE_W-1:0] num_planes_reg;
    logic [pzos_pkg::ZOOM_W-1:0]  begin_zoom_reg;
    logic [pzos_pkg::ZOOM_W-1:0]  end_zoom_reg;
    logic                         luma_flat_reg;

    // Sequence state.
    logic [pzos_pkg::LEVEL_W-1:0] level_reg [MAX_PLANES];
    logic [pzos_pkg::LEVEL_W-1:0] level_next [MAX_PLANES];
    logic [pzos_pkg::COUNT_W-1:0] given_reg;
    logic [pzos_pkg::COUNT_W-1:0] given_next;

    // Input register and result register.
    logic                         in_valid_reg;
    logic                         restart_reg;
    logic                         out_valid_reg;
    logic [pzos_pkg::PLANE_W-1:0] plane_reg;
    logic [pzos_pkg::ZOOM_W-1:0]  zoom_reg;
    logic                         last_reg;
    logic                         past_end_reg;

    logic                         advance;
    logic                         fire;
    logic [pzos_pkg::PLANE_W-1:0] np;
    logic [pzos_pkg::LEVEL_W-1:0] start_level;
    logic [pzos_pkg::LEVEL_W-1:0] eff_level [MAX_PLANES];
    logic [pzos_pkg::COUNT_W-1:0] eff_given;
    logic [pzos_pkg::COUNT_W-1:0] total;
    logic [pzos_pkg::COUNT_W-1:0] given_inc;
    logic [pzos_pkg::LEVEL_W-1:0] new_level;
    logic                         exhausted;
    pzos_pkg::sel_t               sel;

    // The result register frees up when it is empty or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        np = num_planes_reg;
        if (np == '0)
        begin
            np = 3'd1;
        end
        if (np > MAX_NP)
        begin
            np = MAX_NP;
        end
    end

    assign start_level = pzos_pkg::LEVEL_W'({1'b0, begin_zoom_reg} + 7'd1);

    // A restart item works on freshly loaded levels.
    always_comb
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            eff_level[p] = restart_reg ? start_level : level_reg[p];
        end
    end
    assign eff_given = restart_reg ? '0 : given_reg;

    // Sequence length is the plane count times the number of zoom levels; zero when end_zoom lies above begin_zoom.
    always_comb
    begin
        total = '0;
        if (end_zoom_reg <= begin_zoom_reg)
        begin
            total = pzos_pkg::COUNT_W'(np)
                  * pzos_pkg::COUNT_W'({1'b0, begin_zoom_reg - end_zoom_reg} + 7'd1);
        end
    end

    pzos_select #(
        .MAX_PLANES(MAX_PLANES)
    ) u_select (
        .levels    (eff_level),
        .np        (np),
        .end_zoom  (end_zoom_reg),
        .luma_flat (luma_flat_reg),
        .sel       (sel)
    );

    assign exhausted = (eff_given >= total) || !sel.found;
    assign given_inc = eff_given + 9'd1;
    assign new_level = eff_level[sel.plane] - 7'd1;

    always_comb
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            level_next[p] = level_reg[p];
            if (fire)
            begin
                level_next[p] = eff_level[p];
                if (!exhausted && (sel.plane == pzos_pkg::PLANE_W'(p)))
                begin
                    level_next[p] = new_level;
                end
            end
        end
        given_next = given_reg;
        if (fire)
        begin
            given_next = exhausted ? eff_given : given_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_planes_reg <= pzos_pkg::NUM_PLANES_RST;
            begin_zoom_reg <= pzos_pkg::BEGIN_ZOOM_RST;
            end_zoom_reg   <= pzos_pkg::END_ZOOM_RST;
            luma_flat_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pzos_pkg::REG_NUM_PLANES: num_planes_reg <= cfg_data[pzos_pkg::PLANE_W-1:0];
                pzos_pkg::REG_BEGIN_ZOOM: begin_zoom_reg <= cfg_data;
                pzos_pkg::REG_END_ZOOM:   end_zoom_reg   <= cfg_data;
                pzos_pkg::REG_LUMA_FLAT:  luma_flat_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_PLANES; p++)
            begin
                level_reg[p] <= 7'd1;
            end
            given_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            given_reg <= given_next;
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            restart_reg <= restart;
        end
        if (fire)
        begin
            plane_reg    <= exhausted ? '0 : sel.plane;
            zoom_reg     <= exhausted ? '0 : new_level[pzos_pkg::ZOOM_W-1:0];
            last_reg     <= !exhausted && (given_inc == total);
            past_end_reg <= exhausted;
        end
    end

    assign out_valid = out_valid_reg;
    assign plane     = plane_reg;
    assign zoom      = zoom_reg;
    assign last      = last_reg;
    assign past_end  = past_end_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for plane_zoom_order_scheduler_core.
//
// Every input transfer carries one restart bit and must produce exactly one
// output transfer holding the next (plane, zoom) entry of the interlaced
// coding order. The bench keeps its own copy of the per-plane zoom levels,
// the entry count and the four settings registers. It works out each entry
// at the moment the input transfer is taken and queues it. The monitor
// compares every output transfer field by field with the oldest queued
// entry.
//
// The stimulus starts with a short directed part:
//   - sequence exhaustion straight out of reset;
//   - an out-of-range plane count with luma flat;
//   - an empty sequence, where end_zoom lies above begin_zoom;
//   - settings changed in the middle of a sequence, so that no plane is
//     left unfinished.
// Then comes a run of random phases. Each phase picks new settings and
// sends mostly complete sequences with random overrun. The rest are
// sequences cut short by an early restart, and loose noise items.
// Both channels idle at random, and the pacing changes from phase to phase.
module tb_top;

    localparam int PLANE_LIMIT  = pzos_pkg::DEFAULT_MAX_PLANES;
    localparam int ITEM_TARGET  = 1200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 10;

    // One entry of the coding order as the output channel carries it.
    typedef struct packed {
        logic [pzos_pkg::PLANE_W-1:0] plane;
        logic [pzos_pkg::ZOOM_W-1:0]  zoom;
        logic                         last;
        logic                         past_end;
    } entry_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [pzos_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pzos_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic                            restart   = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [pzos_pkg::PLANE_W-1:0]    plane;
    logic [pzos_pkg::ZOOM_W-1:0]     zoom;
    logic                            last;
    logic                            past_end;

    plane_zoom_order_scheduler_core #(
        .MAX_PLANES (PLANE_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .plane     (plane),
        .zoom      (zoom),
        .last      (last),
        .past_end  (past_end)
    );

    always #10 clk = ~clk;

    // Shadow copy of the settings registers, updated as each write goes out.
    logic [pzos_pkg::PLANE_W-1:0] num_planes_set = pzos_pkg::NUM_PLANES_RST;
    logic [pzos_pkg::ZOOM_W-1:0]  begin_set      = pzos_pkg::BEGIN_ZOOM_RST;
    logic [pzos_pkg::ZOOM_W-1:0]  end_set        = pzos_pkg::END_ZOOM_RST;
    logic                         flat_set       = 1'b0;

    // Shadow copy of the scheduler state. After reset every level is
    // begin_zoom plus one with begin_zoom at its reset value.
    logic [pzos_pkg::LEVEL_W-1:0] level_now [5] =
        '{default: pzos_pkg::LEVEL_W'(pzos_pkg::BEGIN_ZOOM_RST) + 7'd1};
    logic [pzos_pkg::COUNT_W-1:0] entries_done = '0;

    // How far each plane may trail the priority plane. Row 1 applies when
    // the luma range is flat, which pulls the chroma planes in tighter.
    int allowed_lag [2][5] = '{'{0, 2, 4, 0, 0}, '{0, 0, 1, 0, 0}};

    logic   restart_queue [$];
    entry_t expected_entries [$];

    int items_queued   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_pace      = 0;
    int recv_pace      = 0;
    int send_gap       = 0;
    int recv_wait      = 0;
    int stall_left;
    entry_t want;

    // The register value for the plane count is clamped to 1..MAX_PLANES.
    function automatic int plane_count();
        if (num_planes_set == 0)
            return 1;
        if (num_planes_set > PLANE_LIMIT)
            return PLANE_LIMIT;
        return int'(num_planes_set);
    endfunction

    // Number of entries in a full sequence; zero when end lies above begin.
    function automatic int sequence_length();
        if (end_set <= begin_set)
            return plane_count() * (int'(begin_set) - int'(end_set) + 1);
        return 0;
    endfunction

    // Advances the shadow state by one input item and returns its entry.
    function automatic entry_t next_entry(input logic restart_req);
        entry_t e;
        int     np;
        int     total;
        int     prio;
        int     pick;
        bit     found;
        e          = '0;
        e.past_end = 1'b1;
        np         = plane_count();
        if (restart_req)
        begin
            for (int p = 0; p < 5; p++)
                level_now[p] = pzos_pkg::LEVEL_W'(begin_set) + 7'd1;
            entries_done = '0;
        end
        total = sequence_length();
        if (int'(entries_done) >= total)
            return e;
        // The alpha or lookback plane leads when present, else plane 0.
        prio = (np >= 5) ? 4 : (np >= 4) ? 3 : 0;
        pick = prio;
        // A plane that trails too far takes over; the last one in index
        // order wins.
        for (int p = 0; p < np; p++)
            if (int'(level_now[p]) > int'(level_now[prio]) + allowed_lag[flat_set][p])
                pick = p;
        // Skip, with wrap, planes that are already at or below end_zoom.
        found = 1'b0;
        for (int k = 0; k < np; k++)
        begin
            if (!found)
            begin
                if (level_now[pick] > pzos_pkg::LEVEL_W'(end_set))
                    found = 1'b1;
                else
                    pick = (pick + 1) % np;
            end
        end
        if (!found)
            return e;
        level_now[pick] = level_now[pick] - 7'd1;
        entries_done    = entries_done + 9'd1;
        e.plane    = pzos_pkg::PLANE_W'(pick);
        e.zoom     = level_now[pick][pzos_pkg::ZOOM_W-1:0];
        e.last     = (int'(entries_done) == total);
        e.past_end = 1'b0;
        return e;
    endfunction

    // Pacing 0 never idles, 1 draws an idle for every item, 2 idles now and then.
    function automatic int draw_wait(input int pace);
        if (pace == 0)
            return 0;
        if (pace == 2 && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Writes one settings register and mirrors the write into the shadow copy.
    task automatic write_reg(input logic [pzos_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pzos_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            pzos_pkg::REG_NUM_PLANES: num_planes_set = data[pzos_pkg::PLANE_W-1:0];
            pzos_pkg::REG_BEGIN_ZOOM: begin_set      = data[pzos_pkg::ZOOM_W-1:0];
            pzos_pkg::REG_END_ZOOM:   end_set        = data[pzos_pkg::ZOOM_W-1:0];
            pzos_pkg::REG_LUMA_FLAT:  flat_set       = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queues one item with the given restart bit, followed by n_plain items
    // that just ask for the next entry.
    task automatic queue_run(input logic first, input int n_plain);
        restart_queue = {restart_queue, first};
        repeat (n_plain)
            restart_queue = {restart_queue, 1'b0};
        items_queued += n_plain + 1;
    endtask

    // Returns once every queued item has been sent and every entry has come
    // back. Each item yields a result, so nothing is left in flight then.
    // The check runs on the falling edge, after the driver and the monitor
    // have settled.
    task automatic wait_idle();
        while (restart_queue.size() != 0 || in_valid || expected_entries.size() != 0)
            @(negedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    // One phase with fixed settings. Most traffic is complete sequences
    // that run a little past their end. Some sequences are cut short by
    // the next restart, and some items are loose noise. Now and then the
    // settings move in the middle of a sequence.
    task automatic run_phase(input int np_val, input int zb, input int ze, input int flat);
        int len;
        int rounds;
        int kind;
        write_reg(pzos_pkg::REG_NUM_PLANES, {3'($urandom), 3'(np_val)});
        write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'(zb));
        write_reg(pzos_pkg::REG_END_ZOOM, 6'(ze));
        write_reg(pzos_pkg::REG_LUMA_FLAT, {5'($urandom), 1'(flat)});
        send_pace = $urandom_range(0, 2);
        recv_pace = $urandom_range(0, 2);
        len       = sequence_length();
        rounds    = (len > 40) ? 1 : $urandom_range(1, 4);
        repeat (rounds)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                queue_run(1'b1, ((len > 0) ? len - 1 : 0) + $urandom_range(0, 2));
            else if (kind < 9)
                queue_run(1'b1, $urandom_range(0, len));
            else
                repeat ($urandom_range(1, 8))
                    queue_run(1'($urandom_range(0, 1)), 0);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            queue_run(1'b1, $urandom_range(0, len / 2));
            wait_idle();
            if ($urandom_range(0, 1) == 1)
                write_reg(pzos_pkg::REG_END_ZOOM, 6'($urandom));
            else
                write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'($urandom));
            queue_run(1'b0, $urandom_range(0, 3));
        end
        wait_idle();
    endtask

    // Input side. The entry for an item is worked out at the edge where its
    // transfer takes place. A stalled item holds its payload. Once the slot
    // frees up, the sender idles for the gap drawn with the previous item
    // before it offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_entries = {expected_entries, next_entry(restart)};
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (restart_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    restart  <= restart_queue.pop_front();
                    send_gap <= draw_wait(send_pace);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side. Each transfer is checked against the oldest expected
    // entry. After it, the receiver stalls for a freshly drawn number of
    // cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_entries.size() == 0)
                begin
                    report_mismatch($sformatf("entry with nothing expected: plane %0d zoom %0d",
                                              plane, zoom));
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (plane !== want.plane)
                        report_mismatch($sformatf("plane %0d, expected %0d", plane, want.plane));
                    if (zoom !== want.zoom)
                        report_mismatch($sformatf("zoom %0d, expected %0d", zoom, want.zoom));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
                    if (past_end !== want.past_end)
                        report_mismatch($sformatf("past_end %0b, expected %0b",
                                                  past_end, want.past_end));
                end
                stall_left = draw_wait(recv_pace);
            end
            else
            begin
                stall_left = (recv_wait != 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= stall_left;
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog for a hung handshake or a lost entry.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int np_pick;
        int zb;
        int ze;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset there are three planes and one level. Three
        // entries use up the sequence, and the fourth item runs past its end.
        queue_run(1'b0, 3);
        wait_idle();

        // Seven planes act as five, so plane 4 leads. With luma flat the
        // chroma lags are tight. Ten entries are given, then one item runs
        // past the end.
        write_reg(pzos_pkg::REG_NUM_PLANES, 6'd7);
        write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'd1);
        write_reg(pzos_pkg::REG_END_ZOOM, 6'd0);
        write_reg(pzos_pkg::REG_LUMA_FLAT, 6'd1);
        send_pace = 1;
        recv_pace = 1;
        queue_run(1'b1, 10);
        wait_idle();

        // A plane count of zero acts as one. With end_zoom above begin_zoom
        // the sequence is empty.
        write_reg(pzos_pkg::REG_NUM_PLANES, 6'd0);
        write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'd5);
        write_reg(pzos_pkg::REG_END_ZOOM, 6'd6);
        write_reg(pzos_pkg::REG_LUMA_FLAT, 6'd0);
        queue_run(1'b1, 1);
        wait_idle();

        // The sender holds back in the middle of a sequence until every
        // entry is in. Then begin and end move so that every plane is
        // already finished. A restart afterward reloads level 64, which
        // gives zoom 63.
        write_reg(pzos_pkg::REG_NUM_PLANES, 6'd2);
        write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'd3);
        write_reg(pzos_pkg::REG_END_ZOOM, 6'd0);
        send_pace = 2;
        recv_pace = 0;
        queue_run(1'b1, 2);
        wait_idle();
        write_reg(pzos_pkg::REG_BEGIN_ZOOM, 6'd63);
        write_reg(pzos_pkg::REG_END_ZOOM, 6'd4);
        queue_run(1'b0, 0);
        queue_run(1'b1, 0);
        wait_idle();

        // The extremes of the settings come first, then random settings.
        run_phase(5, 63, 0, 0);
        run_phase(1, 63, 63, 1);
        run_phase(7, 0, 0, 0);
        run_phase(4, 2, 0, 1);
        while (items_queued < ITEM_TARGET)
        begin
            np_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            case ($urandom_range(0, 4))
                0:       zb = $urandom_range(0, 63);
                1:       zb = 63;
                default: zb = $urandom_range(0, 5);
            endcase
            case ($urandom_range(0, 9))
                0:       ze = (zb < 63) ? $urandom_range(zb + 1, 63) : 63;
                1:       ze = 0;
                default: ze = (zb > 4) ? $urandom_range(zb - 4, zb) : $urandom_range(0, zb);
            endcase
            run_phase(np_pick, zb, ze, $urandom_range(0, 1));
        end

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pzos_pkg.sv
rtl/pzos_select.sv
rtl/plane_zoom_order_scheduler_core.sv
test/tb_top.sv
